[design/aabb_affine_transform_defines.svh]
// Assertion macros used by the checker of the box transform.
`ifndef AABB_AFFINE_TRANSFORM_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_DEFINES_SVH

// Concurrent assertion sampled on the rising clock, muted while reset is held.
`define AXF_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the next cycle, built on the macro above.
`define AXF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	`AXF_ASSERT(name, clk, rst_n, (ante) |=> (cons), msg)

`endif

[design/aabb_xf_pkg.sv]
// Types, constants and helper functions for the box transform.
package aabb_xf_pkg;

	// Signed Q8.8 coordinate.
	typedef logic signed [15:0] coord_t;

	// Coordinate shifted back from a Q12.20 product to Q12.8, before saturation.
	typedef logic signed [19:0] term_t;

	// Sum of three terms and a translation.
	typedef logic signed [21:0] acc_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_ROW_X = 2'd0,
		CFG_ROW_Y = 2'd1,
		CFG_ROW_Z = 2'd2
	} cfg_idx_t;

	// Stage advance strobes handed to each axis datapath.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	localparam int unsigned ROW_W      = 64;
	localparam int unsigned COEF_SHIFT = 12;
	localparam int unsigned TRANS_LSB  = 48;

	// Identity transform rows.
	localparam logic [ROW_W-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW_Z_RST = 64'h0000_1000_0000_0000;

	localparam coord_t COORD_MAX = 16'sh7fff;
	localparam coord_t COORD_MIN = 16'sh8000;

	// Clamp a wide sum into the signed 16-bit range.
	function automatic coord_t sat16(input acc_t v);
		coord_t r;
		if (v[21:15] == {7{v[21]}}) begin
			r = v[15:0];
		end else if (v[21]) begin
			r = COORD_MIN;
		end else begin
			r = COORD_MAX;
		end
		return r;
	endfunction

endpackage

[design/aabb_xf_row.sv]
// One output axis: products, per-term min and max, sum and saturation.
module aabb_xf_row import aabb_xf_pkg::*; (
	input  logic             clk,
	input  pipe_en_t         en,
	input  logic [ROW_W-1:0] row,
	input  coord_t           lo_s1 [3],
	input  coord_t           hi_s1 [3],
	output coord_t           min_s4,
	output coord_t           max_s4
);

	logic signed [31:0] prod_lo [3];
	logic signed [31:0] prod_hi [3];
	term_t  lo_s2 [3];
	term_t  hi_s2 [3];
	term_t  tmin_s3 [3];
	term_t  tmax_s3 [3];
	coord_t trans;
	acc_t   sum_min;
	acc_t   sum_max;

	// Full products, floored back to Q12.8 by dropping the low fraction bits.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			prod_lo[j] = $signed(row[16*j +: 16]) * lo_s1[j];
			prod_hi[j] = $signed(row[16*j +: 16]) * hi_s1[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int j = 0; j < 3; j++) begin
				lo_s2[j] <= prod_lo[j][31:COEF_SHIFT];
				hi_s2[j] <= prod_hi[j][31:COEF_SHIFT];
			end
		end
	end

	// Each term depends on one coordinate only, so the corner extremes
	// split into independent per-term extremes.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int j = 0; j < 3; j++) begin
				tmin_s3[j] <= (lo_s2[j] < hi_s2[j]) ? lo_s2[j] : hi_s2[j];
				tmax_s3[j] <= (lo_s2[j] < hi_s2[j]) ? hi_s2[j] : lo_s2[j];
			end
		end
	end

	// Add the translation and clamp; clamping is monotone so it commutes
	// with the min and max.
	always_comb begin
		trans   = row[TRANS_LSB +: 16];
		sum_min = acc_t'(tmin_s3[0]) + acc_t'(tmin_s3[1]) + acc_t'(tmin_s3[2])
			+ acc_t'(trans);
		sum_max = acc_t'(tmax_s3[0]) + acc_t'(tmax_s3[1]) + acc_t'(tmax_s3[2])
			+ acc_t'(trans);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			min_s4 <= sat16(sum_min);
			max_s4 <= sat16(sum_max);
		end
	end

endmodule

[design/aabb_affine_transform.sv]
// Top level of the box transform: config rows, input stage and handshake control.
// An accepted item passes through the input register, then the product, min/max and
// result registers before it appears on the output. Throughput: one item per cycle while
// out_ready holds, set by the four-stage pipeline that advances whenever the stage ahead is free.
// Reset clears all stage valid bits and loads the identity transform rows.
module aabb_affine_transform import aabb_xf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [ROW_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  coord_t           in_min_x,
	input  coord_t           in_min_y,
	input  coord_t           in_min_z,
	input  coord_t           in_max_x,
	input  coord_t           in_max_y,
	input  coord_t           in_max_z,
	output logic             out_valid,
	input  logic             out_ready,
	output coord_t           out_min_x,
	output coord_t           out_min_y,
	output coord_t           out_min_z,
	output coord_t           out_max_x,
	output coord_t           out_max_y,
	output coord_t           out_max_z
);

	logic [ROW_W-1:0] row_x_q;
	logic [ROW_W-1:0] row_y_q;
	logic [ROW_W-1:0] row_z_q;
	logic     v_s1, v_s2, v_s3, v_s4;
	logic     rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	pipe_en_t en;
	coord_t   lo_s1 [3];
	coord_t   hi_s1 [3];

	// Configuration rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= ROW_X_RST;
			row_y_q <= ROW_Y_RST;
			row_z_q <= ROW_Z_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW_X: row_x_q <= cfg_data;
				CFG_ROW_Y: row_y_q <= cfg_data;
				CFG_ROW_Z: row_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage takes new data when it is empty or its item moves on.
	always_comb begin
		rdy_s4   = !v_s4 || out_ready;
		rdy_s3   = !v_s3 || rdy_s4;
		rdy_s2   = !v_s2 || rdy_s3;
		rdy_s1   = !v_s1 || rdy_s2;
		in_ready = rdy_s1;
		en.s2    = rdy_s2;
		en.s3    = rdy_s3;
		en.s4    = rdy_s4;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Input register for the box corners.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			lo_s1[0] <= in_min_x;
			lo_s1[1] <= in_min_y;
			lo_s1[2] <= in_min_z;
			hi_s1[0] <= in_max_x;
			hi_s1[1] <= in_max_y;
			hi_s1[2] <= in_max_z;
		end
	end

	// One datapath per output axis.
	aabb_xf_row u_row_x (
		.clk    (clk),
		.en     (en),
		.row    (row_x_q),
		.lo_s1  (lo_s1),
		.hi_s1  (hi_s1),
		.min_s4 (out_min_x),
		.max_s4 (out_max_x)
	);

	aabb_xf_row u_row_y (
		.clk    (clk),
		.en     (en),
		.row    (row_y_q),
		.lo_s1  (lo_s1),
		.hi_s1  (hi_s1),
		.min_s4 (out_min_y),
		.max_s4 (out_max_y)
	);

	aabb_xf_row u_row_z (
		.clk    (clk),
		.en     (en),
		.row    (row_z_q),
		.lo_s1  (lo_s1),
		.hi_s1  (hi_s1),
		.min_s4 (out_min_z),
		.max_s4 (out_max_z)
	);

	assign out_valid = v_s4;

endmodule

[design/aabb_xf_checker.sv]
// Port-level checks for the box transform and their binding to the top level.
`include "aabb_affine_transform_defines.svh"

module aabb_xf_checker import aabb_xf_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input coord_t out_min_x,
	input coord_t out_min_y,
	input coord_t out_min_z,
	input coord_t out_max_x,
	input coord_t out_max_y,
	input coord_t out_max_z
);

	logic box_ok;

	// Each axis of the result box has its minimum at or below its maximum.
	assign box_ok = (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
		&& (out_min_z <= out_max_z);

	// A stalled result item stays offered.
	`AXF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")

	// A waiting input item stays offered.
	`AXF_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid, "input item dropped")

	// The bounding box of the corners is never inverted.
	`AXF_ASSERT(a_box_order, clk, arst_n, out_valid |-> box_ok, "result box has min above max")

	// With the result register empty the whole pipeline can move.
	`AXF_ASSERT(a_ready_empty, clk, arst_n, !out_valid |-> in_ready, "input stalled, output empty")

	// A result register that can drain frees every stage behind it.
	`AXF_ASSERT(a_ready_pass, clk, arst_n, out_ready |-> in_ready, "input stalled, output open")

endmodule

bind aabb_affine_transform aabb_xf_checker u_aabb_xf_checker (.*);
